// ----- hw/rtl/crcwsz_pkg.sv -----
// Shared types, constants and the word fold function of the CRC-32 word stream block.
// Used by the channel interfaces and by every module under hw/rtl.
package crcwsz_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 32;
    localparam int PEND_W      = 24;
    localparam int POS_W       = 2;
    localparam int QUEUE_DEPTH = 2;

    // APB register map: one 32-bit register per word address
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_IDX_INIT_VALUE = 1'b0;

    localparam logic [WORD_W-1:0] CRC_POLY   = 32'h04C1_1DB7;
    localparam logic [WORD_W-1:0] INIT_RESET = 32'hFFFF_FFFF;
    localparam logic [POS_W-1:0]  POS_LAST   = 2'd3;

    // One packed word on its way from the packer to the fold unit
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } word_item_t;

    // Restart request from the register port, with the value to load
    typedef struct packed {
        logic              restart;
        logic [WORD_W-1:0] init;
    } cfg_ctrl_t;

    typedef logic [WORD_W-1:0] fold_cols_t [WORD_W];

    // Column i is the 32-step MSB-first fold of a single set bit i
    function automatic fold_cols_t make_fold_cols();
        fold_cols_t cols;
        logic [WORD_W-1:0] c;
        for (int i = 0; i < WORD_W; i++)
        begin
            c = WORD_W'(1) << i;
            for (int k = 0; k < WORD_W; k++)
            begin
                c = c[WORD_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
            end
            cols[i] = c;
        end
        return cols;
    endfunction

    localparam fold_cols_t FOLD_COLS = make_fold_cols();

    // Fold one word into the CRC: XOR tree over the precomputed columns
    function automatic logic [WORD_W-1:0] fold_word(logic [WORD_W-1:0] crc,
                                                    logic [WORD_W-1:0] word);
        logic [WORD_W-1:0] v;
        logic [WORD_W-1:0] acc;
        v   = crc ^ word;
        acc = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (v[i])
            begin
                acc = acc ^ FOLD_COLS[i];
            end
        end
        return acc;
    endfunction

endpackage

// ----- hw/rtl/crcwsz_intf.sv -----
// Valid/ready channel interfaces for the byte input and the CRC result.
// Depends on crcwsz_pkg for field widths.
interface crcwsz_byte_if;
    logic                           valid;
    logic                           ready;
    logic [crcwsz_pkg::BYTE_W-1:0]  data_byte;
    logic                           last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface crcwsz_crc_if;
    logic                           valid;
    logic                           ready;
    logic [crcwsz_pkg::WORD_W-1:0]  crc_value;

    modport source (output valid, output crc_value, input ready);
    modport sink (input valid, input crc_value, output ready);
endinterface

// ----- hw/rtl/crcwsz_pack.sv -----
// Front end: accepts message bytes and packs them little-endian into 32-bit words.
// Depends on crcwsz_pkg and crcwsz_byte_if; feeds words to the queue.
module crcwsz_pack (
    input  logic                   clk,
    input  logic                   rst_n,
    crcwsz_byte_if.sink            in_ch,
    input  crcwsz_pkg::cfg_ctrl_t  cfg_ctrl,
    output logic                   push_valid,
    output crcwsz_pkg::word_item_t push_item,
    input  logic                   push_ready
);

    logic [crcwsz_pkg::POS_W-1:0]  pos_reg;
    logic [crcwsz_pkg::POS_W-1:0]  pos_next;
    logic [crcwsz_pkg::PEND_W-1:0] pend_reg;
    logic [crcwsz_pkg::PEND_W-1:0] pend_next;
    logic [crcwsz_pkg::WORD_W-1:0] word;
    logic                          accept;
    logic                          word_done;

    // Take a byte whenever the queue has room
    assign in_ch.ready = push_ready;
    assign accept      = in_ch.valid && push_ready;

    // Place the new byte above the bytes already held
    assign word = {{(crcwsz_pkg::WORD_W - crcwsz_pkg::PEND_W){1'b0}}, pend_reg}
                | ({{(crcwsz_pkg::WORD_W - crcwsz_pkg::BYTE_W){1'b0}}, in_ch.data_byte}
                   << {pos_reg, 3'b000});

    assign word_done = in_ch.last || (pos_reg == crcwsz_pkg::POS_LAST);

    // Emit a word on the fourth byte or on the last byte (zero-padded tail)
    assign push_valid     = accept && word_done;
    assign push_item.word = word;
    assign push_item.last = in_ch.last;

    // Advance byte position, drop the partial word on completion or restart
    always_comb
    begin
        pos_next  = pos_reg;
        pend_next = pend_reg;
        if (cfg_ctrl.restart)
        begin
            pos_next  = '0;
            pend_next = '0;
        end
        else if (accept)
        begin
            if (word_done)
            begin
                pos_next  = '0;
                pend_next = '0;
            end
            else
            begin
                pos_next  = pos_reg + 1'b1;
                pend_next = word[crcwsz_pkg::PEND_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            pend_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            pend_reg <= pend_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A last byte always closes the word
    a_last_resets_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.last) |=> (pos_reg == '0))
        else $error("byte position not cleared after last byte");
`endif

endmodule

// ----- hw/rtl/crcwsz_queue.sv -----
// Short word queue between the packer and the fold unit.
// Depends on crcwsz_pkg for the item type; depth set by the top level.
module crcwsz_queue #(
    parameter int DEPTH = crcwsz_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_valid,
    input  crcwsz_pkg::word_item_t push_item,
    output logic                   push_ready,
    output logic                   pop_valid,
    output crcwsz_pkg::word_item_t pop_item,
    input  logic                   pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    crcwsz_pkg::word_item_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers with wrap, track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef NO_ASSERTIONS
    // Fill level stays within the queue depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill level beyond depth");
`endif

endmodule

// ----- hw/rtl/crcwsz_fold.sv -----
// Back end: folds queued words into the running CRC and holds the result beat.
// Depends on crcwsz_pkg (fold_word) and crcwsz_crc_if.
module crcwsz_fold (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pop_valid,
    input  crcwsz_pkg::word_item_t pop_item,
    output logic                   pop_ready,
    input  crcwsz_pkg::cfg_ctrl_t  cfg_ctrl,
    crcwsz_crc_if.source           out_ch
);

    logic [crcwsz_pkg::WORD_W-1:0] crc_reg;
    logic [crcwsz_pkg::WORD_W-1:0] crc_next;
    logic [crcwsz_pkg::WORD_W-1:0] res_reg;
    logic [crcwsz_pkg::WORD_W-1:0] res_next;
    logic                          res_valid_reg;
    logic                          res_valid_next;
    logic [crcwsz_pkg::WORD_W-1:0] folded;
    logic                          pop;

    // Take a word while the result register is free or being drained
    assign pop_ready = !res_valid_reg || out_ch.ready;
    assign pop       = pop_valid && pop_ready;
    assign folded    = crcwsz_pkg::fold_word(crc_reg, pop_item.word);

    assign out_ch.valid     = res_valid_reg;
    assign out_ch.crc_value = res_reg;

    // Fold, emit on last and reload the initial value
    always_comb
    begin
        crc_next       = crc_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (out_ch.ready)
        begin
            res_valid_next = 1'b0;
        end
        if (cfg_ctrl.restart)
        begin
            crc_next = cfg_ctrl.init;
        end
        else if (pop)
        begin
            if (pop_item.last)
            begin
                crc_next       = cfg_ctrl.init;
                res_next       = folded;
                res_valid_next = 1'b1;
            end
            else
            begin
                crc_next = folded;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= crcwsz_pkg::INIT_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

`ifndef NO_ASSERTIONS
    // A last word always produces a result beat unless a restart comes in the same cycle
    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pop_item.last && !cfg_ctrl.restart) |=> res_valid_reg)
        else $error("last word did not produce a result");

    // A result beat only appears after a last word
    a_emit_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(pop && pop_item.last))
        else $error("result beat without a last word");
`endif

endmodule

// ----- hw/rtl/crc32_word_stream_zero_pad.sv -----
// CRC-32 (poly 0x04C11DB7, MSB first, no final XOR) over bytes packed into LE words.
// Throughput: one byte per cycle while the queue has room; the fold unit folds one 32-bit word
// per cycle unless its result beat is held; the CRC beat passes the queue, then the fold unit.
// Reset: init_value = 0xFFFFFFFF, CRC loaded with it, packer, queue and result cleared.
// Writing init_value also reloads the CRC and drops any partial word.
module crc32_word_stream_zero_pad #(
    parameter int QUEUE_DEPTH = crcwsz_pkg::QUEUE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [crcwsz_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [crcwsz_pkg::APB_DATA_W-1:0] pwdata,
    output logic [crcwsz_pkg::APB_DATA_W-1:0] prdata,
    output logic                              pready,
    crcwsz_byte_if.sink                       in_ch,
    crcwsz_crc_if.source                      out_ch
);

    logic [crcwsz_pkg::WORD_W-1:0] init_value_reg;
    logic [crcwsz_pkg::WORD_W-1:0] init_value_next;
    logic                          init_sel;
    logic                          init_wr;
    crcwsz_pkg::cfg_ctrl_t         cfg_ctrl;
    logic                          push_valid;
    logic                          push_ready;
    crcwsz_pkg::word_item_t        push_item;
    logic                          pop_valid;
    logic                          pop_ready;
    crcwsz_pkg::word_item_t        pop_item;

    // Decode the register port
    assign pready   = 1'b1;
    assign init_sel = (paddr[crcwsz_pkg::APB_ADDR_W-1:2] == crcwsz_pkg::REG_IDX_INIT_VALUE);
    assign init_wr  = psel && penable && pwrite && init_sel;
    assign prdata   = init_sel ? init_value_reg : '0;

    assign init_value_next   = init_wr ? pwdata : init_value_reg;
    assign cfg_ctrl.restart  = init_wr;
    assign cfg_ctrl.init     = init_value_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_value_reg <= crcwsz_pkg::INIT_RESET;
        end
        else
        begin
            init_value_reg <= init_value_next;
        end
    end

    crcwsz_pack u_pack (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .cfg_ctrl   (cfg_ctrl),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    crcwsz_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    crcwsz_fold u_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop_ready (pop_ready),
        .cfg_ctrl  (cfg_ctrl),
        .out_ch    (out_ch)
    );

endmodule

// ----- tb/sv/crc32_word_stream_zero_pad_tb.sv -----
// Self-checking testbench for crc32_word_stream_zero_pad: byte beats in, CRC beats out, APB setup.
// Depends on crcwsz_pkg, the crcwsz_byte_if / crcwsz_crc_if channels and the block's RTL.
// A local bit-serial CRC predictor computes every expected CRC beat from the accepted bytes.
module crc32_word_stream_zero_pad_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 505;
    localparam int MAX_REPORTS    = 10;

    localparam logic [crcwsz_pkg::REG_IDX_W-1:0] REG_IDX_SPARE = 1'b1;

    typedef struct packed {
        logic [crcwsz_pkg::BYTE_W-1:0] data_byte;
        logic                          last;
    } byte_beat_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [crcwsz_pkg::APB_ADDR_W-1:0] paddr;
    logic [crcwsz_pkg::APB_DATA_W-1:0] pwdata;
    logic [crcwsz_pkg::APB_DATA_W-1:0] prdata;
    logic pready;

    crcwsz_byte_if byte_ch ();
    crcwsz_crc_if  crc_ch ();

    crc32_word_stream_zero_pad u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (byte_ch),
        .out_ch  (crc_ch)
    );

    // Stimulus and expectation stores
    byte_beat_t                    byte_feed_q[$];
    logic [crcwsz_pkg::WORD_W-1:0] crc_expect_q[$];

    // Predictor state
    logic [crcwsz_pkg::WORD_W-1:0] init_shadow;
    logic [crcwsz_pkg::WORD_W-1:0] crc_run;
    logic [crcwsz_pkg::PEND_W-1:0] pend_word;
    logic [crcwsz_pkg::POS_W-1:0]  pend_count;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned phase_num;
    logic        hold_off;
    int unsigned stall_cycles;

    int unsigned mismatch_count;
    int unsigned bytes_taken;
    int unsigned crc_checked;
    int unsigned msg_count;
    int unsigned reg_writes;

    // Clock: 8 ns period
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // MSB-first fold of one word, one shift per bit
    function automatic logic [crcwsz_pkg::WORD_W-1:0] fold_msb_first(
        logic [crcwsz_pkg::WORD_W-1:0] crc,
        logic [crcwsz_pkg::WORD_W-1:0] word);
        logic [crcwsz_pkg::WORD_W-1:0] r;
        r = crc ^ word;
        for (int k = 0; k < crcwsz_pkg::WORD_W; k++)
        begin
            r = r[crcwsz_pkg::WORD_W-1] ? ((r << 1) ^ crcwsz_pkg::CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    function automatic logic [crcwsz_pkg::APB_ADDR_W-1:0] reg_addr(
        logic [crcwsz_pkg::REG_IDX_W-1:0] idx);
        return {idx, 2'b00};
    endfunction

    task automatic restart_crc();
        crc_run    = init_shadow;
        pend_word  = '0;
        pend_count = '0;
    endtask

    // Pack one byte little-endian; fold on a full word or on last
    task automatic absorb_byte(input byte_beat_t beat);
        logic [crcwsz_pkg::WORD_W-1:0] word;
        word = {{crcwsz_pkg::BYTE_W{1'b0}}, pend_word}
             | (crcwsz_pkg::WORD_W'(beat.data_byte) << (crcwsz_pkg::BYTE_W * pend_count));
        if (beat.last)
        begin
            crc_expect_q.push_back(fold_msb_first(crc_run, word));
            restart_crc();
        end
        else if (pend_count == crcwsz_pkg::POS_LAST)
        begin
            crc_run    = fold_msb_first(crc_run, word);
            pend_word  = '0;
            pend_count = '0;
        end
        else
        begin
            pend_word  = word[crcwsz_pkg::PEND_W-1:0];
            pend_count = pend_count + 1'b1;
        end
    endtask

    task automatic note_mismatch(input string what,
                                 input logic [crcwsz_pkg::WORD_W-1:0] exp_val,
                                 input logic [crcwsz_pkg::WORD_W-1:0] act_val);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("[%0t] mismatch on %s: expected 0x%08h, got 0x%08h",
                     $realtime, what, exp_val, act_val);
        end
    endtask

    // Byte driver: hold a beat until taken, else offer the next one or idle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                absorb_byte(byte_feed_q.pop_front());
                bytes_taken++;
            end
            if (!(byte_ch.valid && !byte_ch.ready))
            begin
                if (byte_feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    byte_ch.valid     <= 1'b1;
                    byte_ch.data_byte <= byte_feed_q[0].data_byte;
                    byte_ch.last      <= byte_feed_q[0].last;
                end
                else
                begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    // CRC monitor: check each beat against the oldest expectation, stall at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (crc_ch.valid && crc_ch.ready)
            begin
                if (crc_expect_q.size() == 0)
                begin
                    note_mismatch("unexpected CRC beat", '0, crc_ch.crc_value);
                end
                else
                begin
                    if (crc_ch.crc_value !== crc_expect_q[0])
                    begin
                        note_mismatch("crc_value", crc_expect_q[0], crc_ch.crc_value);
                    end
                    void'(crc_expect_q.pop_front());
                    crc_checked++;
                end
            end
            crc_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long receiver hold-off in the last phase so the block backs up
    initial
    begin
        hold_off = 1'b0;
        wait (phase_num == 3);
        repeat (16) @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog: count cycles with no beat and no register access
    always @(posedge clk)
    begin
        if ((byte_ch.valid && byte_ch.ready) || (crc_ch.valid && crc_ch.ready) || psel)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", stall_cycles);
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic apb_write(input logic [crcwsz_pkg::APB_ADDR_W-1:0] addr,
                             input logic [crcwsz_pkg::APB_DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        reg_writes++;
    endtask

    task automatic apb_read(input logic [crcwsz_pkg::APB_ADDR_W-1:0] addr,
                            output logic [crcwsz_pkg::APB_DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_init_readback();
        logic [crcwsz_pkg::APB_DATA_W-1:0] rd;
        apb_read(reg_addr(crcwsz_pkg::REG_IDX_INIT_VALUE), rd);
        if (rd !== init_shadow)
        begin
            note_mismatch("init_value readback", init_shadow, rd);
        end
    endtask

    // Write init_value; this restarts the CRC and drops any partial word
    task automatic write_init(input logic [crcwsz_pkg::WORD_W-1:0] value);
        apb_write(reg_addr(crcwsz_pkg::REG_IDX_INIT_VALUE), value);
        init_shadow = value;
        restart_crc();
        check_init_readback();
    endtask

    // Wait until every byte is taken and every CRC has come back
    task automatic drain();
        while (byte_feed_q.size() != 0 || byte_ch.valid)
        begin
            @(posedge clk);
        end
        while (crc_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_beat(input logic [crcwsz_pkg::BYTE_W-1:0] b, input logic last);
        byte_beat_t beat;
        beat.data_byte = b;
        beat.last      = last;
        byte_feed_q.push_back(beat);
        if (last)
        begin
            msg_count++;
        end
    endtask

    task automatic push_message(input logic [crcwsz_pkg::BYTE_W-1:0] msg[]);
        foreach (msg[i])
        begin
            push_beat(msg[i], i == msg.size() - 1);
        end
    endtask

    task automatic push_random_bytes(input int unsigned len, input logic close_msg);
        for (int unsigned i = 0; i < len; i++)
        begin
            push_beat(crcwsz_pkg::BYTE_W'($urandom), close_msg && (i == len - 1));
        end
    endtask

    // Mostly short messages, some long ones that fold many words
    task automatic push_random_messages(input int unsigned n_items);
        int unsigned left;
        int unsigned len;
        left = n_items;
        while (left > 0)
        begin
            if ($urandom_range(99) < 85)
            begin
                len = $urandom_range(12, 1);
            end
            else
            begin
                len = $urandom_range(64, 13);
            end
            if (len > left)
            begin
                len = left;
            end
            push_random_bytes(len, 1'b1);
            left -= len;
        end
    endtask

    task automatic start_phase(input int unsigned num, input int unsigned send_pct,
                               input int unsigned recv_pct);
        @(negedge clk);
        phase_num     = num;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Main sequence: reset, directed messages, then three random phases
    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.last      = 1'b0;
        crc_ch.ready      = 1'b0;
        stall_cycles      = 0;
        mismatch_count    = 0;
        bytes_taken       = 0;
        crc_checked       = 0;
        msg_count         = 0;
        reg_writes        = 0;
        phase_num         = 0;
        send_idle_pct     = 32;
        recv_idle_pct     = 64;
        init_shadow       = crcwsz_pkg::INIT_RESET;
        restart_crc();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset value of init_value
        check_init_readback();

        // Directed: single bytes, each tail length, a full word, fold plus tail
        start_phase(0, 32, 64);
        push_message('{8'h00});
        push_message('{8'hFF});
        push_message('{8'h80, 8'h01});
        push_message('{8'hFF, 8'h00, 8'hFF});
        push_message('{8'h01, 8'h02, 8'h03, 8'h04});
        push_message('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h5A});
        push_message('{8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'hDE, 8'hF0});
        drain();

        // Phase 1: all-zero init, sender idles less than receiver
        write_init('0);
        start_phase(1, 32, 64);
        push_random_messages(PHASE_ITEMS);
        push_random_bytes(2, 1'b0);
        drain();

        // Spare register index: ignored, so the open message carries on
        apb_write(reg_addr(REG_IDX_SPARE), $urandom);
        check_init_readback();
        start_phase(1, 32, 64);
        push_random_bytes(3, 1'b1);
        push_random_bytes(3, 1'b0);
        drain();

        // Phase 2: all-ones init abandons the open message; roles swapped
        write_init('1);
        start_phase(2, 64, 32);
        push_random_messages(PHASE_ITEMS);
        drain();

        // Phase 3: random init, no idling, one long receiver hold-off
        write_init(crcwsz_pkg::WORD_W'($urandom));
        start_phase(3, 0, 0);
        push_random_messages(PHASE_ITEMS);
        drain();

        if (crc_expect_q.size() != 0)
        begin
            note_mismatch("leftover expectation", crc_expect_q[0], '0);
        end

        $display("Covered %0d bytes in %0d messages, %0d CRC beats checked, %0d register writes.",
                 bytes_taken, msg_count, crc_checked, reg_writes);
        $display("Init values: reset, zero, all ones, random; spare write and dropped tails too.");
        if (mismatch_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("%0d mismatches", mismatch_count);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
